/* sv/cmt_pkg.sv */
// Shared types, constants and request codes of the compare match timer.
package cmt_pkg;

  localparam int CHANNELS   = 4;
  localparam int COUNT_BITS = 32;

  localparam int REQ_W      = 3;
  localparam int CHAN_W     = 3;
  localparam int VALUE_W    = 32;
  localparam int READ_W     = 32;
  localparam int MASK_W     = 4;
  localparam int PRESCALE_W = 16;
  localparam int TOP_W      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SET_ABS  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET_REL  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DISARM   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_START    = 3'd5;
  localparam logic [REQ_W-1:0] REQ_STOP     = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE_DIV = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_VALUE    = 8'd1;

  localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd0;
  localparam logic [TOP_W-1:0]      TOP_RESET      = 32'd65535;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [CHAN_W-1:0]  channel;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [READ_W-1:0] read_data;
    logic [MASK_W-1:0] fired_mask;
    logic              error;
  } result_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

/* sv/cmt_exec.sv */
// Timer state, configuration registers and the per-transaction update logic.
module cmt_exec (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  cmt_pkg::item_t  item,
  input  cmt_pkg::cfg_wr_t cfg,
  output cmt_pkg::result_t res
);

  logic [cmt_pkg::PRESCALE_W-1:0] prescale_div;
  logic [cmt_pkg::TOP_W-1:0]      top_value;
  logic [cmt_pkg::PRESCALE_W-1:0] prescale_count, prescale_count_next;
  logic [cmt_pkg::COUNT_BITS-1:0] count, count_next;
  logic [cmt_pkg::COUNT_BITS-1:0] compare_value [cmt_pkg::CHANNELS];
  logic [cmt_pkg::COUNT_BITS-1:0] compare_value_next [cmt_pkg::CHANNELS];
  logic [cmt_pkg::CHANNELS-1:0]   match_flags, match_flags_next;
  logic [cmt_pkg::CHANNELS-1:0]   armed, armed_next;
  logic                           running, running_next;

  logic [cmt_pkg::COUNT_BITS-1:0] top_eff;
  logic [cmt_pkg::COUNT_BITS-1:0] set_value;
  logic [cmt_pkg::CHANNELS-1:0]   armed_mid, fired;
  logic                           chan_ok, step, err;

  assign top_eff = top_value[cmt_pkg::COUNT_BITS-1:0];
  assign chan_ok = item.channel < cmt_pkg::CHAN_W'(cmt_pkg::CHANNELS);

  always_comb begin
    prescale_count_next = prescale_count;
    count_next          = count;
    compare_value_next  = compare_value;
    match_flags_next    = match_flags;
    armed_mid           = armed;
    running_next        = running;
    step                = 1'b0;
    err                 = 1'b0;
    set_value           = item.value[cmt_pkg::COUNT_BITS-1:0];

    unique case (item.req_type) inside
      cmt_pkg::REQ_TICK: begin
        if (running) begin
          if (prescale_count >= prescale_div) begin
            prescale_count_next = '0;
            step                = 1'b1;
          end else begin
            prescale_count_next = prescale_count + 1'b1;
          end
        end
      end
      cmt_pkg::REQ_SET_ABS, cmt_pkg::REQ_SET_REL: begin
        if (item.req_type == cmt_pkg::REQ_SET_REL) begin
          set_value = count + item.value[cmt_pkg::COUNT_BITS-1:0];
        end
        if (!chan_ok) begin
          err = 1'b1;
        end else begin
          for (int i = 0; i < cmt_pkg::CHANNELS; i++) begin
            if (item.channel == cmt_pkg::CHAN_W'(i)) begin
              compare_value_next[i] = set_value & top_eff;
              match_flags_next[i]   = 1'b0;
              armed_mid[i]          = 1'b1;
            end
          end
        end
      end
      cmt_pkg::REQ_DISARM: begin
        if (!chan_ok) begin
          err = 1'b1;
        end else begin
          for (int i = 0; i < cmt_pkg::CHANNELS; i++) begin
            if (item.channel == cmt_pkg::CHAN_W'(i)) begin
              armed_mid[i] = 1'b0;
            end
          end
        end
      end
      cmt_pkg::REQ_START: running_next = 1'b1;
      cmt_pkg::REQ_STOP:  running_next = 1'b0;
      default: ;
    endcase

    // The counter wraps at top; above top (top just lowered) it runs on to its
    // natural wrap. Each compare channel latches a match on the new count.
    if (step) begin
      if (count == top_eff) begin
        count_next = '0;
      end else begin
        count_next = count + 1'b1;
      end
      for (int i = 0; i < cmt_pkg::CHANNELS; i++) begin
        if (compare_value[i] == count_next) begin
          match_flags_next[i] = 1'b1;
        end
      end
    end

    fired      = match_flags_next & armed_mid;
    armed_next = armed_mid & ~fired;
  end

  assign res.read_data  = cmt_pkg::READ_W'(count_next);
  assign res.fired_mask = cmt_pkg::MASK_W'(fired);
  assign res.error      = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_div   <= cmt_pkg::PRESCALE_RESET;
      top_value      <= cmt_pkg::TOP_RESET;
      prescale_count <= '0;
      count          <= '0;
      match_flags    <= '0;
      armed          <= '0;
      running        <= 1'b1;
      for (int i = 0; i < cmt_pkg::CHANNELS; i++) begin
        compare_value[i] <= '0;
      end
    end else begin
      if (cfg.we) begin
        unique case (cfg.index)
          cmt_pkg::REG_PRESCALE_DIV: prescale_div <= cfg.data[cmt_pkg::PRESCALE_W-1:0];
          cmt_pkg::REG_TOP_VALUE:    top_value    <= cfg.data[cmt_pkg::TOP_W-1:0];
          default: ;
        endcase
      end
      if (en) begin
        prescale_count <= prescale_count_next;
        count          <= count_next;
        compare_value  <= compare_value_next;
        match_flags    <= match_flags_next;
        armed          <= armed_next;
        running        <= running_next;
      end
    end
  end

  // A flagged channel that is still armed would have fired and been disarmed.
  assert property (@(posedge clk) disable iff (rst) (armed & match_flags) == '0)
    else $error("channel left both armed and flagged");

  assert property (@(posedge clk) disable iff (rst) !en |=> $stable(prescale_count))
    else $error("prescale count moved without a transaction");

  assert property (@(posedge clk) disable iff (rst)
    (en && res.error) |-> (item.req_type == cmt_pkg::REQ_SET_ABS ||
                           item.req_type == cmt_pkg::REQ_SET_REL ||
                           item.req_type == cmt_pkg::REQ_DISARM))
    else $error("error flagged on a request without a channel");

  assert property (@(posedge clk) disable iff (rst)
    $fell(running) |-> $past(en && item.req_type == cmt_pkg::REQ_STOP))
    else $error("timer stopped without a stop request");

endmodule

/* sv/compare_match_timer_core.sv */
// Top level of the compare match timer: stream ports, input and result registers.
//
//  channel   direction  transaction carries
//  s_axis    in         tuser: req_type; tdata: channel, value
//  m_axis    out        tdata: read_data, fired_mask, error
//  cfg       in         cfg_index selects prescale_div (0) or top_value (1)
//
// Every request is held in an input register, evaluated by the update logic
// and written to the result register once that register is empty or draining;
// it stays there until m_axis takes it. One transaction is taken every cycle
// while m_axis_tready stays high. The single pass through the state update
// sets that rate.
// Reset is synchronous and active high; it clears the counter, flags and
// channel arming, starts the timer and loads the configuration defaults.
// A stall on m_axis holds the result; the input register still takes one more
// transaction, and s_axis_tready falls only while both registers are full.
// Configuration writes are always accepted and take effect on the next cycle.
module compare_match_timer_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Bits [2:0] channel, [34:3] value, [39:35] zero.
  input  logic [cmt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Bits [2:0] req_type.
  input  logic [cmt_pkg::REQ_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Bits [31:0] read_data, [35:32] fired_mask, [36] error, [39:37] zero.
  output logic [cmt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cmt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cmt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic             in_valid;
  cmt_pkg::item_t   in_item;
  logic             out_valid;
  cmt_pkg::result_t out_res;
  cmt_pkg::result_t res;
  cmt_pkg::cfg_wr_t cfg;
  logic             advance;

  // The held request moves on when the result register is empty or draining.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  assign cfg.we    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.req_type <= s_axis_tuser;
      in_item.channel  <= s_axis_tdata[cmt_pkg::CHAN_W-1:0];
      in_item.value    <= s_axis_tdata[cmt_pkg::CHAN_W +: cmt_pkg::VALUE_W];
    end
  end

  cmt_exec u_exec (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_res.error, out_res.fired_mask, out_res.read_data};

endmodule
